FILE: rtl/asdf_pkg.sv
// package for the analytic sdf union unit: sizes, codes, sequencer states
// and the structs passed between the sequencer, the store and the top level
// depends on nothing
package asdf_pkg;

   // table size and fixed-point format
   localparam int MAX_PRIMITIVES = 8;
   localparam int FRAC_BITS      = 16;
   localparam int ROT_WORDS      = 9;
   localparam int ENTRY_W        = (MAX_PRIMITIVES > 1) ? $clog2(MAX_PRIMITIVES) : 1;
   localparam int CNT_W          = $clog2(MAX_PRIMITIVES + 1);
   localparam int ROT_AW         = $clog2(MAX_PRIMITIVES * ROT_WORDS);

   // request types
   localparam logic [1:0] REQ_LOAD_POSE = 2'd0;
   localparam logic [1:0] REQ_LOAD_QUAT = 2'd1;
   localparam logic [1:0] REQ_LOAD_SIZE = 2'd2;
   localparam logic [1:0] REQ_QUERY     = 2'd3;

   // shape kinds
   localparam logic [2:0] KIND_RBOX     = 3'd0;
   localparam logic [2:0] KIND_BOX      = 3'd1;
   localparam logic [2:0] KIND_CYLINDER = 3'd2;
   localparam logic [2:0] KIND_CAPSULE  = 3'd3;
   localparam logic [2:0] KIND_SPHERE   = 3'd4;

   // result status
   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_EMPTY   = 2'd1;
   localparam logic [1:0] STAT_BADKIND = 2'd2;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_QSCALE,
      ST_QSQ_MUL,
      ST_QSQ_ACC,
      ST_QPR_MUL,
      ST_QPR_DIV,
      ST_QPR_WAIT,
      ST_QWR,
      ST_PRIM,
      ST_DIFF,
      ST_ROT_RD,
      ST_ROT_MUL,
      ST_ROT_ACC,
      ST_SHAPE,
      ST_SHAPE2,
      ST_N_SHIFT,
      ST_N_MUL,
      ST_N_ACC,
      ST_N_ROOT,
      ST_N_WAIT,
      ST_CYL1,
      ST_CYL2,
      ST_FIN,
      ST_BEST,
      ST_DONE
   } asdf_state_type;

   // store write controls
   typedef struct packed {
      logic                    pose_we;
      logic                    size_we;
      logic                    rot_we;
      logic [ENTRY_W-1:0]      entry;
      logic [2:0]              kind;
      logic [3:0][31:0]        words;
      logic [ROT_AW-1:0]       rot_addr;
      logic [31:0]             rot_data;
   } store_wr_type;

   // store read data
   typedef struct packed {
      logic [MAX_PRIMITIVES-1:0][2:0] kinds;
      logic [2:0][31:0]               trans;
      logic [3:0][31:0]               sizes;
      logic [31:0]                    rot;
   } store_rd_type;

   // finished result from the sequencer
   typedef struct packed {
      logic               valid;
      logic signed [31:0] distance;
      logic [1:0]         status;
   } result_type;

endpackage

FILE: rtl/asdf_if.sv
// channel interfaces of the analytic sdf union unit: request and response
// plain valid/ready channels, no package needed
interface asdf_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         req_type;
   logic [2:0]         entry_index;
   logic [2:0]         shape_kind;
   logic signed [31:0] value_a;
   logic signed [31:0] value_b;
   logic signed [31:0] value_c;
   logic signed [31:0] value_d;

   modport source (
      output valid, req_type, entry_index, shape_kind, value_a, value_b, value_c, value_d,
      input  ready
   );
   modport sink (
      input  valid, req_type, entry_index, shape_kind, value_a, value_b, value_c, value_d,
      output ready
   );
endinterface

interface asdf_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] distance;
   logic [1:0]         status;

   modport source (output valid, distance, status, input ready);
   modport sink   (input valid, distance, status, output ready);
endinterface

FILE: rtl/asdf_store.sv
// primitive table: kinds in flops, translation and size rows and the
// rotation words in memories with registered reads; uses asdf_pkg
module asdf_store
   import asdf_pkg::*;
(
   input  logic               clock,
   input  store_wr_type       wr,
   input  logic [ENTRY_W-1:0] rd_entry,
   input  logic [ROT_AW-1:0]  rot_raddr,
   output store_rd_type       rd
);

   logic [MAX_PRIMITIVES-1:0][2:0] kind_ff;
   logic [2:0][31:0]               trans_mem [MAX_PRIMITIVES];
   logic [3:0][31:0]               size_mem  [MAX_PRIMITIVES];
   logic [31:0]                    rot_mem   [MAX_PRIMITIVES * ROT_WORDS];
   logic [2:0][31:0]               trans_ff;
   logic [3:0][31:0]               size_ff;
   logic [31:0]                    rot_ff;

   // writes
   always_ff @(posedge clock) begin
      if (wr.pose_we) begin
         kind_ff[wr.entry]   <= wr.kind;
         trans_mem[wr.entry] <= wr.words[2:0];
      end
      if (wr.size_we) begin
         size_mem[wr.entry] <= wr.words;
      end
      if (wr.rot_we) begin
         rot_mem[wr.rot_addr] <= wr.rot_data;
      end
   end

   // registered reads
   always_ff @(posedge clock) begin
      trans_ff <= trans_mem[rd_entry];
      size_ff  <= size_mem[rd_entry];
      rot_ff   <= rot_mem[rot_raddr];
   end

   assign rd.kinds = kind_ff;
   assign rd.trans = trans_ff;
   assign rd.sizes = size_ff;
   assign rd.rot   = rot_ff;

endmodule

FILE: rtl/asdf_mul.sv
// shared signed multiplier, 33 by 33 bits, product registered
// no package dependency
module asdf_mul (
   input  logic               clock,
   input  logic signed [32:0] mul_a,
   input  logic signed [32:0] mul_b,
   output logic signed [63:0] mul_p
);

   logic signed [65:0] full;
   logic signed [63:0] prod_ff;

   assign full = mul_a * mul_b;

   // one product a cycle
   always_ff @(posedge clock) begin
      prod_ff <= full[63:0];
   end

   assign mul_p = prod_ff;

endmodule

FILE: rtl/asdf_div.sv
// iterative unsigned divider, 64 by 64 bits, one quotient bit a cycle
// no package dependency
module asdf_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [63:0] divisor,
   output logic        done,
   output logic [63:0] quotient
);

   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [64:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [63:0] dvs_ff, dvs_in;
   logic [64:0] rem_sh;

   // restoring step
   always_comb begin
      rem_sh  = {rem_ff[63:0], quo_ff[63]};
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         rem_in = '0;
         quo_in = dividend;
         dvs_in = divisor;
      end else if (run_ff) begin
         if (rem_sh >= {1'b0, dvs_ff}) begin
            rem_in = rem_sh - {1'b0, dvs_ff};
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: rtl/asdf_isqrt.sv
// iterative floor square root of a 64-bit value, one result bit a cycle
// no package dependency
module asdf_isqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] radicand,
   output logic        done,
   output logic [31:0] root
);

   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [63:0] val_ff, val_in;
   logic [63:0] res_ff, res_in;
   logic [63:0] bit_ff, bit_in;
   logic [63:0] trial;

   // digit-by-digit step
   always_comb begin
      trial   = res_ff + bit_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      val_in  = val_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         val_in = radicand;
         res_in = '0;
         bit_in = 64'h4000_0000_0000_0000;
      end else if (run_ff) begin
         if (val_ff >= trial) begin
            val_in = val_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      val_ff <= val_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign done = done_ff;
   assign root = res_ff[31:0];

endmodule

FILE: rtl/asdf_seq.sv
// sequencer of the analytic sdf union unit: loads, quaternion to matrix,
// per-primitive transform, shape distance and union minimum
// uses asdf_pkg, asdf_if and the shared multiplier, divider and root units
module asdf_seq
   import asdf_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   asdf_req_if.sink           req,
   input  logic [3:0]         prim_count,
   input  logic               rsp_free,
   input  store_rd_type       rd,
   output store_wr_type       wr,
   output logic [ENTRY_W-1:0] rd_entry,
   output logic [ROT_AW-1:0]  rot_raddr,
   output logic signed [32:0] mul_a,
   output logic signed [32:0] mul_b,
   input  logic signed [63:0] mul_p,
   output logic               div_start,
   output logic [63:0]        div_num,
   output logic [63:0]        div_den,
   input  logic               div_done,
   input  logic [63:0]        div_quo,
   output logic               sq_start,
   output logic [63:0]        sq_val,
   input  logic               sq_done,
   input  logic [31:0]        sq_root,
   output result_type         res
);

   asdf_state_type     state_ff, state_in;
   asdf_state_type     rtn_ff, rtn_in;
   logic [CNT_W-1:0]   i_ff, i_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [3:0]         k_ff, k_in;
   logic [1:0]         j_ff, j_in;
   logic signed [63:0] acc_ff, acc_in;
   logic signed [31:0] p_ff [3], p_in [3];
   logic signed [32:0] d_ff [3], d_in [3];
   logic signed [63:0] l_ff [3], l_in [3];
   logic signed [63:0] h_ff [3], h_in [3];
   logic signed [63:0] q_ff [3], q_in [3];
   logic [63:0]        n_ff [3], n_in [3];
   logic [5:0]         s_ff, s_in;
   logic [63:0]        sq_ff, sq_in;
   logic signed [63:0] norm_ff, norm_in;
   logic signed [63:0] v_ff, v_in;
   logic signed [63:0] best_ff, best_in;
   logic [1:0]         status_ff, status_in;
   logic signed [31:0] qv_ff [4], qv_in [4];
   logic [ENTRY_W-1:0] qe_ff, qe_in;
   logic [63:0]        n2_ff, n2_in;
   logic               neg_ff, neg_in;
   logic signed [31:0] qt_ff [9], qt_in [9];

   logic [2:0]         kind_cur;
   logic signed [63:0] sz [4];
   logic [31:0]        qm;
   logic signed [31:0] one32;

   function automatic logic [63:0] mag64(input logic signed [63:0] v);
      mag64 = v[63] ? 64'(-v) : 64'(v);
   endfunction

   function automatic logic [31:0] mag32(input logic signed [31:0] v);
      mag32 = v[31] ? 32'(-v) : 32'(v);
   endfunction

   function automatic logic signed [63:0] max0(input logic signed [63:0] v);
      max0 = v[63] ? 64'sd0 : v;
   endfunction

   function automatic logic signed [63:0] smax(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
      smax = (a > b) ? a : b;
   endfunction

   assign kind_cur  = rd.kinds[i_ff[ENTRY_W-1:0]];
   assign rd_entry  = i_ff[ENTRY_W-1:0];
   assign rot_raddr = ROT_AW'(ROT_AW'(i_ff[ENTRY_W-1:0]) * ROT_AW'(ROT_WORDS)
                      + ROT_AW'(k_ff) * ROT_AW'(3) + ROT_AW'(j_ff));
   assign one32     = 32'sd1 <<< FRAC_BITS;
   assign div_den   = n2_ff >> FRAC_BITS;
   assign sq_val    = sq_ff;

   // sizes of the current entry, sign extended
   always_comb begin
      for (int w = 0; w < 4; w++) begin
         sz[w] = 64'(signed'(rd.sizes[w]));
      end
   end

   // largest quaternion component magnitude
   always_comb begin
      qm = mag32(qv_ff[0]);
      for (int w = 1; w < 4; w++) begin
         if (mag32(qv_ff[w]) > qm) qm = mag32(qv_ff[w]);
      end
   end

   // next state and datapath control
   always_comb begin
      logic [CNT_W-1:0]   cnt_sel;
      logic [1:0]         stat;
      logic signed [63:0] acc_sum;
      logic signed [63:0] numer;
      logic signed [63:0] cl;
      logic signed [63:0] best_new;
      logic [63:0]        mx;
      logic [1:0]         ua;
      logic [1:0]         ub;
      logic signed [31:0] rw;

      state_in  = state_ff;
      rtn_in    = rtn_ff;
      i_in      = i_ff;
      cnt_in    = cnt_ff;
      k_in      = k_ff;
      j_in      = j_ff;
      acc_in    = acc_ff;
      p_in      = p_ff;
      d_in      = d_ff;
      l_in      = l_ff;
      h_in      = h_ff;
      q_in      = q_ff;
      n_in      = n_ff;
      s_in      = s_ff;
      sq_in     = sq_ff;
      norm_in   = norm_ff;
      v_in      = v_ff;
      best_in   = best_ff;
      status_in = status_ff;
      qv_in     = qv_ff;
      qe_in     = qe_ff;
      n2_in     = n2_ff;
      neg_in    = neg_ff;
      qt_in     = qt_ff;

      wr        = '0;
      mul_a     = '0;
      mul_b     = '0;
      div_start = 1'b0;
      div_num   = '0;
      sq_start  = 1'b0;
      res       = '0;
      req.ready = (state_ff == ST_IDLE);

      cnt_sel   = '0;
      stat      = STAT_OK;
      acc_sum   = '0;
      numer     = '0;
      cl        = '0;
      best_new  = '0;
      mx        = '0;
      ua        = '0;
      ub        = '0;
      rw        = '0;

      unique case (state_ff)
         // accept a beat
         ST_IDLE: begin
            if (req.valid) begin
               unique case (req.req_type)
                  REQ_LOAD_POSE: begin
                     wr.pose_we  = (32'(req.entry_index) < MAX_PRIMITIVES);
                     wr.entry    = ENTRY_W'(req.entry_index);
                     wr.kind     = req.shape_kind;
                     wr.words[0] = req.value_a;
                     wr.words[1] = req.value_b;
                     wr.words[2] = req.value_c;
                  end
                  REQ_LOAD_SIZE: begin
                     wr.size_we  = (32'(req.entry_index) < MAX_PRIMITIVES);
                     wr.entry    = ENTRY_W'(req.entry_index);
                     wr.words[0] = req.value_a;
                     wr.words[1] = req.value_b;
                     wr.words[2] = req.value_c;
                     wr.words[3] = req.value_d;
                  end
                  REQ_LOAD_QUAT: begin
                     qv_in[0] = req.value_a;
                     qv_in[1] = req.value_b;
                     qv_in[2] = req.value_c;
                     qv_in[3] = req.value_d;
                     qe_in    = ENTRY_W'(req.entry_index);
                     k_in     = '0;
                     if (32'(req.entry_index) < MAX_PRIMITIVES) begin
                        if (req.value_a == 0 && req.value_b == 0 &&
                            req.value_c == 0 && req.value_d == 0) begin
                           // zero quaternion stores the identity
                           for (int w = 0; w < 9; w++) qt_in[w] = '0;
                           state_in = ST_QWR;
                        end else begin
                           state_in = ST_QSCALE;
                        end
                     end
                  end
                  REQ_QUERY: begin
                     p_in[0] = req.value_a;
                     p_in[1] = req.value_b;
                     p_in[2] = req.value_c;
                     cnt_sel = (32'(prim_count) > MAX_PRIMITIVES) ?
                               CNT_W'(MAX_PRIMITIVES) : CNT_W'(prim_count);
                     if (cnt_sel == '0) stat = STAT_EMPTY;
                     for (int e = 0; e < MAX_PRIMITIVES; e++) begin
                        if (CNT_W'(e) < cnt_sel && rd.kinds[e] > KIND_SPHERE) begin
                           stat = STAT_BADKIND;
                        end
                     end
                     cnt_in    = cnt_sel;
                     status_in = stat;
                     i_in      = '0;
                     best_in   = '0;
                     state_in  = (stat == STAT_OK) ? ST_PRIM : ST_DONE;
                  end
                  default: ;
               endcase
            end
         end

         // bring the largest component into [2^29, 2^30)
         ST_QSCALE: begin
            if (qm >= 32'h4000_0000) begin
               for (int w = 0; w < 4; w++) begin
                  qv_in[w] = (qv_ff[w] + $signed({31'b0, qv_ff[w][31]})) >>> 1;
               end
            end else if (qm < 32'h2000_0000) begin
               for (int w = 0; w < 4; w++) qv_in[w] = qv_ff[w] <<< 1;
            end else begin
               k_in     = '0;
               n2_in    = '0;
               state_in = ST_QSQ_MUL;
            end
         end

         // squared norm
         ST_QSQ_MUL: begin
            mul_a    = 33'(qv_ff[k_ff[1:0]]);
            mul_b    = 33'(qv_ff[k_ff[1:0]]);
            state_in = ST_QSQ_ACC;
         end
         ST_QSQ_ACC: begin
            n2_in = n2_ff + 64'(mul_p);
            if (k_ff == 4'd3) begin
               k_in     = '0;
               state_in = ST_QPR_MUL;
            end else begin
               k_in     = k_ff + 4'd1;
               state_in = ST_QSQ_MUL;
            end
         end

         // pair products over the norm: xx yy zz xy xz yz wx wy wz
         ST_QPR_MUL: begin
            unique case (k_ff)
               4'd0:    begin ua = 2'd1; ub = 2'd1; end
               4'd1:    begin ua = 2'd2; ub = 2'd2; end
               4'd2:    begin ua = 2'd3; ub = 2'd3; end
               4'd3:    begin ua = 2'd1; ub = 2'd2; end
               4'd4:    begin ua = 2'd1; ub = 2'd3; end
               4'd5:    begin ua = 2'd2; ub = 2'd3; end
               4'd6:    begin ua = 2'd0; ub = 2'd1; end
               4'd7:    begin ua = 2'd0; ub = 2'd2; end
               default: begin ua = 2'd0; ub = 2'd3; end
            endcase
            mul_a    = 33'(qv_ff[ua]);
            mul_b    = 33'(qv_ff[ub]);
            state_in = ST_QPR_DIV;
         end
         ST_QPR_DIV: begin
            numer     = mul_p <<< 1;
            neg_in    = numer[63];
            div_num   = mag64(numer);
            div_start = 1'b1;
            state_in  = ST_QPR_WAIT;
         end
         ST_QPR_WAIT: begin
            if (div_done) begin
               qt_in[k_ff] = neg_ff ? -$signed(div_quo[31:0]) : $signed(div_quo[31:0]);
               if (k_ff == 4'd8) begin
                  k_in     = '0;
                  state_in = ST_QWR;
               end else begin
                  k_in     = k_ff + 4'd1;
                  state_in = ST_QPR_MUL;
               end
            end
         end

         // matrix words, row major
         ST_QWR: begin
            unique case (k_ff)
               4'd0:    rw = one32 - qt_ff[1] - qt_ff[2];
               4'd1:    rw = qt_ff[3] - qt_ff[8];
               4'd2:    rw = qt_ff[4] + qt_ff[7];
               4'd3:    rw = qt_ff[3] + qt_ff[8];
               4'd4:    rw = one32 - qt_ff[0] - qt_ff[2];
               4'd5:    rw = qt_ff[5] - qt_ff[6];
               4'd6:    rw = qt_ff[4] - qt_ff[7];
               4'd7:    rw = qt_ff[5] + qt_ff[6];
               default: rw = one32 - qt_ff[0] - qt_ff[1];
            endcase
            wr.rot_we   = 1'b1;
            wr.rot_addr = ROT_AW'(ROT_AW'(qe_ff) * ROT_AW'(ROT_WORDS) + ROT_AW'(k_ff));
            wr.rot_data = rw;
            if (k_ff == 4'd8) begin
               k_in     = '0;
               state_in = ST_IDLE;
            end else begin
               k_in = k_ff + 4'd1;
            end
         end

         // row read of the current entry
         ST_PRIM: state_in = ST_DIFF;
         ST_DIFF: begin
            for (int w = 0; w < 3; w++) begin
               d_in[w] = $signed({p_ff[w][31], p_ff[w]}) -
                         $signed({rd.trans[w][31], rd.trans[w]});
            end
            j_in     = '0;
            k_in     = '0;
            acc_in   = '0;
            state_in = ST_ROT_RD;
         end

         // local frame, one product at a time
         ST_ROT_RD: state_in = ST_ROT_MUL;
         ST_ROT_MUL: begin
            mul_a    = d_ff[k_ff[1:0]];
            mul_b    = 33'(signed'(rd.rot));
            state_in = ST_ROT_ACC;
         end
         ST_ROT_ACC: begin
            acc_sum = acc_ff + mul_p;
            if (k_ff == 4'd2) begin
               l_in[j_ff] = acc_sum >>> FRAC_BITS;
               acc_in     = '0;
               k_in       = '0;
               if (j_ff == 2'd2) begin
                  state_in = ST_SHAPE;
               end else begin
                  j_in     = j_ff + 2'd1;
                  state_in = ST_ROT_RD;
               end
            end else begin
               acc_in   = acc_sum;
               k_in     = k_ff + 4'd1;
               state_in = ST_ROT_RD;
            end
         end

         // half sizes, less the rounding radius for a rounded box
         ST_SHAPE: begin
            for (int w = 0; w < 3; w++) begin
               h_in[w] = (sz[w] >>> 1) - ((kind_cur == KIND_RBOX) ? sz[3] : 64'sd0);
            end
            state_in = ST_SHAPE2;
         end

         // norm operands per kind
         ST_SHAPE2: begin
            s_in     = '0;
            rtn_in   = ST_FIN;
            state_in = ST_N_SHIFT;
            unique case (kind_cur)
               KIND_RBOX, KIND_BOX: begin
                  for (int w = 0; w < 3; w++) begin
                     q_in[w] = $signed(mag64(l_ff[w])) - h_ff[w];
                     n_in[w] = 64'(max0(q_in[w]));
                  end
               end
               KIND_CYLINDER: begin
                  n_in[0] = mag64(l_ff[0]);
                  n_in[1] = mag64(l_ff[1]);
                  n_in[2] = '0;
                  q_in[1] = $signed(mag64(l_ff[2])) - h_ff[0];
                  rtn_in  = ST_CYL1;
               end
               KIND_CAPSULE: begin
                  cl = l_ff[2];
                  if (cl < -h_ff[0]) cl = -h_ff[0];
                  if (cl > h_ff[0]) cl = h_ff[0];
                  n_in[0] = mag64(l_ff[0]);
                  n_in[1] = mag64(l_ff[1]);
                  n_in[2] = mag64(l_ff[2] - cl);
               end
               default: begin
                  for (int w = 0; w < 3; w++) n_in[w] = mag64(l_ff[w]);
               end
            endcase
         end

         // euclidean norm: scale below 2^31, squares, root, scale back
         ST_N_SHIFT: begin
            mx = n_ff[0];
            if (n_ff[1] > mx) mx = n_ff[1];
            if (n_ff[2] > mx) mx = n_ff[2];
            if (mx[63:31] != '0) begin
               for (int w = 0; w < 3; w++) n_in[w] = n_ff[w] >> 1;
               s_in = s_ff + 6'd1;
            end else begin
               k_in     = '0;
               sq_in    = '0;
               state_in = ST_N_MUL;
            end
         end
         ST_N_MUL: begin
            mul_a    = {1'b0, n_ff[k_ff[1:0]][31:0]};
            mul_b    = {1'b0, n_ff[k_ff[1:0]][31:0]};
            state_in = ST_N_ACC;
         end
         ST_N_ACC: begin
            sq_in = sq_ff + 64'(mul_p);
            if (k_ff == 4'd2) begin
               k_in     = '0;
               state_in = ST_N_ROOT;
            end else begin
               k_in     = k_ff + 4'd1;
               state_in = ST_N_MUL;
            end
         end
         ST_N_ROOT: begin
            sq_start = 1'b1;
            state_in = ST_N_WAIT;
         end
         ST_N_WAIT: begin
            if (sq_done) begin
               norm_in  = $signed(64'(sq_root) << s_ff);
               state_in = rtn_ff;
            end
         end

         // cylinder: radial and axial excess, then the outside norm
         ST_CYL1: begin
            q_in[0]  = norm_ff - sz[1];
            state_in = ST_CYL2;
         end
         ST_CYL2: begin
            n_in[0]  = 64'(max0(q_ff[0]));
            n_in[1]  = 64'(max0(q_ff[1]));
            n_in[2]  = '0;
            s_in     = '0;
            rtn_in   = ST_FIN;
            state_in = ST_N_SHIFT;
         end

         // distance of this primitive
         ST_FIN: begin
            unique case (kind_cur)
               KIND_RBOX, KIND_BOX: begin
                  cl   = smax(q_ff[0], smax(q_ff[1], q_ff[2]));
                  v_in = norm_ff + (cl[63] ? cl : 64'sd0)
                         - ((kind_cur == KIND_RBOX) ? sz[3] : 64'sd0);
               end
               KIND_CYLINDER: begin
                  cl   = smax(q_ff[0], q_ff[1]);
                  v_in = (cl[63] ? cl : 64'sd0) + norm_ff;
               end
               KIND_CAPSULE: v_in = norm_ff - sz[1];
               default:      v_in = norm_ff - sz[0];
            endcase
            state_in = ST_BEST;
         end

         // running minimum
         ST_BEST: begin
            best_new = (i_ff == '0 || v_ff < best_ff) ? v_ff : best_ff;
            best_in  = best_new;
            if (i_ff + CNT_W'(1) == cnt_ff) begin
               state_in = ST_DONE;
            end else begin
               i_in     = i_ff + CNT_W'(1);
               state_in = ST_PRIM;
            end
         end

         // hand the result to the output register
         ST_DONE: begin
            if (rsp_free) begin
               res.valid  = 1'b1;
               res.status = status_ff;
               if (best_ff > 64'sh7FFF_FFFF) begin
                  res.distance = 32'sh7FFF_FFFF;
               end else if (best_ff < -64'sh8000_0000) begin
                  res.distance = 32'sh8000_0000;
               end else begin
                  res.distance = best_ff[31:0];
               end
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      rtn_ff    <= rtn_in;
      i_ff      <= i_in;
      cnt_ff    <= cnt_in;
      k_ff      <= k_in;
      j_ff      <= j_in;
      acc_ff    <= acc_in;
      p_ff      <= p_in;
      d_ff      <= d_in;
      l_ff      <= l_in;
      h_ff      <= h_in;
      q_ff      <= q_in;
      n_ff      <= n_in;
      s_ff      <= s_in;
      sq_ff     <= sq_in;
      norm_ff   <= norm_in;
      v_ff      <= v_in;
      best_ff   <= best_in;
      status_ff <= status_in;
      qv_ff     <= qv_in;
      qe_ff     <= qe_in;
      n2_ff     <= n2_in;
      neg_ff    <= neg_in;
      qt_ff     <= qt_in;
   end

endmodule

FILE: rtl/analytic_sdf_union_unit.sv
// top level of the analytic sdf union unit: count register, response register
// uses asdf_pkg, asdf_if, asdf_store, asdf_mul, asdf_div, asdf_isqrt, asdf_seq
//
//  channel    direction  beat
//  req_chan   in         req_type, entry_index, shape_kind, value_a..value_d
//  rsp_chan   out        distance, status (one beat per query, none per load)
//  csr_wr_*   in         primitive_count, 4 bits
//
// pose and size loads are written as they are accepted; a zero quaternion writes
// the identity matrix words, any other is scaled, takes its squared norm and has
// each pair product divided on the 64-step divider. A query walks the primitives
// in turn; each norm scales its operands, squares them and takes the root on the
// 32-step root unit; a cylinder takes two norms, all on the shared multiplier.
// Sync reset clears the count and the control state; the table is undefined.
// A finished result sits in the response register while the next beat is taken.
module analytic_sdf_union_unit
   import asdf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   asdf_req_if.sink   req_chan,
   asdf_rsp_if.source rsp_chan,
   input  logic       csr_wr_en,
   input  logic [3:0] csr_wr_data
);

   logic [3:0]         count_ff;
   logic               rsp_valid_ff;
   logic signed [31:0] rsp_dist_ff;
   logic [1:0]         rsp_stat_ff;
   logic               rsp_free;

   store_wr_type       wr;
   store_rd_type       rd;
   logic [ENTRY_W-1:0] rd_entry;
   logic [ROT_AW-1:0]  rot_raddr;
   logic signed [32:0] mul_a;
   logic signed [32:0] mul_b;
   logic signed [63:0] mul_p;
   logic               div_start;
   logic [63:0]        div_num;
   logic [63:0]        div_den;
   logic               div_done;
   logic [63:0]        div_quo;
   logic               sq_start;
   logic [63:0]        sq_val;
   logic               sq_done;
   logic [31:0]        sq_root;
   result_type         res;

   // primitive count register
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_wr_en) begin
         count_ff <= csr_wr_data;
      end
   end

   // response register
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (res.valid) begin
         rsp_dist_ff <= res.distance;
         rsp_stat_ff <= res.status;
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.distance = rsp_dist_ff;
   assign rsp_chan.status   = rsp_stat_ff;

   asdf_store u_store (
      .clock     (clock),
      .wr        (wr),
      .rd_entry  (rd_entry),
      .rot_raddr (rot_raddr),
      .rd        (rd)
   );

   asdf_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (mul_p)
   );

   asdf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_quo)
   );

   asdf_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (sq_val),
      .done     (sq_done),
      .root     (sq_root)
   );

   asdf_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .prim_count (count_ff),
      .rsp_free   (rsp_free),
      .rd         (rd),
      .wr         (wr),
      .rd_entry   (rd_entry),
      .rot_raddr  (rot_raddr),
      .mul_a      (mul_a),
      .mul_b      (mul_b),
      .mul_p      (mul_p),
      .div_start  (div_start),
      .div_num    (div_num),
      .div_den    (div_den),
      .div_done   (div_done),
      .div_quo    (div_quo),
      .sq_start   (sq_start),
      .sq_val     (sq_val),
      .sq_done    (sq_done),
      .sq_root    (sq_root),
      .res        (res)
   );

endmodule

FILE: dv/tb_analytic_sdf_union_unit.sv
// testbench for the analytic sdf union unit: loads a primitive table, sends
// queries and compares each distance and status beat against its own predictor
// depends on asdf_pkg, asdf_if and analytic_sdf_union_unit
module tb_analytic_sdf_union_unit;
   import asdf_pkg::*;

   typedef struct {
      logic [1:0]         op;
      logic [2:0]         entry;
      logic [2:0]         kind;
      logic signed [31:0] va;
      logic signed [31:0] vb;
      logic signed [31:0] vc;
      logic signed [31:0] vd;
   } sdf_beat_type;

   typedef struct {
      logic signed [31:0] dvalue;
      logic [1:0]         stat;
   } sdf_result_type;

   localparam int DRAIN_CYCLES = 2000;
   localparam int STALL_LIMIT  = 60000;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [3:0] csr_wr_data;

   asdf_req_if req_bus ();
   asdf_rsp_if rsp_bus ();

   analytic_sdf_union_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus.sink),
      .rsp_chan    (rsp_bus.source),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // predictor state: table copy and primitive count
   logic [2:0] shape_tbl [MAX_PRIMITIVES];
   int         offset_tbl [MAX_PRIMITIVES][3];
   int         rot_tbl [MAX_PRIMITIVES][9];
   int         dims_tbl [MAX_PRIMITIVES][4];
   int         active_count;

   sdf_result_type pending_dist[$];
   int  mismatches;
   int  idle_cycles;
   int  send_gap_pct;
   int  rsp_stall_pct;
   int  rsp_hold_left;

   // clock
   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // fixed-point helpers
   function automatic longint unsigned magnitude(longint v);
      return (v < 0) ? longint'(-v) : v;
   endfunction

   function automatic longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned res;
      longint unsigned bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v   = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic longint euclid(longint a, longint b, longint c);
      longint unsigned m0, m1, m2, mx;
      int s;
      m0 = magnitude(a);
      m1 = magnitude(b);
      m2 = magnitude(c);
      mx = (m0 > m1) ? m0 : m1;
      if (m2 > mx) mx = m2;
      s = 0;
      while ((mx >> s) >= (64'd1 << 31)) s++;
      m0 = m0 >> s;
      m1 = m1 >> s;
      m2 = m2 >> s;
      return longint'(floor_sqrt(m0 * m0 + m1 * m1 + m2 * m2) << s);
   endfunction

   function automatic longint lmax(longint a, longint b);
      return (a > b) ? a : b;
   endfunction

   function automatic longint lmin(longint a, longint b);
      return (a < b) ? a : b;
   endfunction

   // quaternion to rotation matrix, scaled so the largest part is in [2^29, 2^30)
   task automatic store_rotation(int e, longint w, longint x, longint y, longint z);
      longint one, den;
      longint unsigned m, n2;
      longint xx, yy, zz, xy, xz, yz, wx, wy, wz;
      one = 64'sd1 <<< FRAC_BITS;
      m = magnitude(w);
      if (magnitude(x) > m) m = magnitude(x);
      if (magnitude(y) > m) m = magnitude(y);
      if (magnitude(z) > m) m = magnitude(z);
      if (m == 0) begin
         for (int k = 0; k < 9; k++) rot_tbl[e][k] = 0;
         rot_tbl[e][0] = int'(one);
         rot_tbl[e][4] = int'(one);
         rot_tbl[e][8] = int'(one);
         return;
      end
      while (m >= (64'd1 << 30)) begin
         w = w / 2; x = x / 2; y = y / 2; z = z / 2;
         m = m >> 1;
      end
      while (m < (64'd1 << 29)) begin
         w = w * 2; x = x * 2; y = y * 2; z = z * 2;
         m = m << 1;
      end
      n2  = longint'(w * w) + longint'(x * x) + longint'(y * y) + longint'(z * z);
      den = longint'(n2 >> FRAC_BITS);
      xx = (2 * x * x) / den; yy = (2 * y * y) / den; zz = (2 * z * z) / den;
      xy = (2 * x * y) / den; xz = (2 * x * z) / den; yz = (2 * y * z) / den;
      wx = (2 * w * x) / den; wy = (2 * w * y) / den; wz = (2 * w * z) / den;
      rot_tbl[e][0] = int'(one - yy - zz);
      rot_tbl[e][1] = int'(xy - wz);
      rot_tbl[e][2] = int'(xz + wy);
      rot_tbl[e][3] = int'(xy + wz);
      rot_tbl[e][4] = int'(one - xx - zz);
      rot_tbl[e][5] = int'(yz - wx);
      rot_tbl[e][6] = int'(xz - wy);
      rot_tbl[e][7] = int'(yz + wx);
      rot_tbl[e][8] = int'(one - xx - yy);
   endtask

   function automatic longint box_gap(longint l[3], longint h[3], longint rnd);
      longint q0, q1, q2;
      q0 = longint'(magnitude(l[0])) - h[0];
      q1 = longint'(magnitude(l[1])) - h[1];
      q2 = longint'(magnitude(l[2])) - h[2];
      return euclid(lmax(q0, 0), lmax(q1, 0), lmax(q2, 0))
             + lmin(lmax(q0, lmax(q1, q2)), 0) - rnd;
   endfunction

   // distance from a query point to one table entry
   function automatic longint shape_distance(int e, longint p[3]);
      longint d[3], l[3], h[3], s[4];
      longint acc, d1, d2, half, c;
      for (int j = 0; j < 3; j++) d[j] = p[j] - offset_tbl[e][j];
      for (int j = 0; j < 3; j++) begin
         acc = 0;
         for (int k = 0; k < 3; k++) acc += d[k] * longint'(rot_tbl[e][k * 3 + j]);
         l[j] = acc >>> FRAC_BITS;
      end
      for (int j = 0; j < 4; j++) s[j] = dims_tbl[e][j];
      case (shape_tbl[e])
         KIND_RBOX: begin
            for (int j = 0; j < 3; j++) h[j] = (s[j] >>> 1) - s[3];
            return box_gap(l, h, s[3]);
         end
         KIND_BOX: begin
            for (int j = 0; j < 3; j++) h[j] = s[j] >>> 1;
            return box_gap(l, h, 0);
         end
         KIND_CYLINDER: begin
            d1 = euclid(l[0], l[1], 0) - s[1];
            d2 = longint'(magnitude(l[2])) - (s[0] >>> 1);
            return lmin(lmax(d1, d2), 0) + euclid(lmax(d1, 0), lmax(d2, 0), 0);
         end
         KIND_CAPSULE: begin
            half = s[0] >>> 1;
            c = l[2];
            if (c < -half) c = -half;
            if (c > half) c = half;
            return euclid(l[0], l[1], l[2] - c) - s[1];
         end
         default: return euclid(l[0], l[1], l[2]) - s[0];
      endcase
   endfunction

   // apply an accepted beat to the table, queue the distance a query yields
   task automatic absorb_beat(sdf_beat_type b);
      sdf_result_type r;
      longint p[3], v, best;
      int n;
      case (b.op)
         REQ_LOAD_POSE: begin
            shape_tbl[b.entry]     = b.kind;
            offset_tbl[b.entry][0] = b.va;
            offset_tbl[b.entry][1] = b.vb;
            offset_tbl[b.entry][2] = b.vc;
         end
         REQ_LOAD_QUAT: store_rotation(b.entry, b.va, b.vb, b.vc, b.vd);
         REQ_LOAD_SIZE: begin
            dims_tbl[b.entry][0] = b.va;
            dims_tbl[b.entry][1] = b.vb;
            dims_tbl[b.entry][2] = b.vc;
            dims_tbl[b.entry][3] = b.vd;
         end
         default: begin
            n = (active_count > MAX_PRIMITIVES) ? MAX_PRIMITIVES : active_count;
            p[0] = b.va; p[1] = b.vb; p[2] = b.vc;
            r.stat = (n == 0) ? STAT_EMPTY : STAT_OK;
            for (int i = 0; i < n; i++)
               if (shape_tbl[i] > KIND_SPHERE) r.stat = STAT_BADKIND;
            best = 0;
            if (r.stat == STAT_OK) begin
               for (int i = 0; i < n; i++) begin
                  v = shape_distance(i, p);
                  if (i == 0 || v < best) best = v;
               end
               if (best > 64'sd2147483647) best = 64'sd2147483647;
               if (best < -64'sd2147483648) best = -64'sd2147483648;
            end
            r.dvalue = best[31:0];
            pending_dist.insert(pending_dist.size(), r);
         end
      endcase
   endtask

   // drive one beat, with random gaps ahead of it
   task automatic send_beat(sdf_beat_type b);
      while ($urandom_range(99) < send_gap_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.req_type    <= b.op;
      req_bus.entry_index <= b.entry;
      req_bus.shape_kind  <= b.kind;
      req_bus.value_a     <= b.va;
      req_bus.value_b     <= b.vb;
      req_bus.value_c     <= b.vc;
      req_bus.value_d     <= b.vd;
      do @(posedge clock); while (!req_bus.ready);
      absorb_beat(b);
   endtask

   // drop valid, wait for every result, then let a load in flight finish
   task automatic drain_all();
      req_bus.valid <= 1'b0;
      while (pending_dist.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_count(int n);
      drain_all();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= n[3:0];
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      active_count = n;
   endtask

   function automatic sdf_beat_type make_beat(logic [1:0] op, int e, int k,
                                              int a, int b, int c, int d);
      sdf_beat_type t;
      t.op = op; t.entry = e[2:0]; t.kind = k[2:0];
      t.va = a; t.vb = b; t.vc = c; t.vd = d;
      return t;
   endfunction

   // mostly a few units in Q16.16, now and then any 32-bit value
   function automatic int rand_fixed(int span_units);
      if ($urandom_range(9) == 0) return int'($urandom);
      return $urandom_range(2 * span_units * 65536) - span_units * 65536;
   endfunction

   function automatic sdf_beat_type rand_load(logic [1:0] op);
      sdf_beat_type t;
      int k;
      k = ($urandom_range(19) == 0) ? $urandom_range(7, 5) : $urandom_range(4);
      t = make_beat(op, $urandom_range(7), ($urandom_range(9) == 0) ? $urandom_range(7) : k,
                    rand_fixed(8), rand_fixed(8), rand_fixed(8), rand_fixed(1));
      if (op == REQ_LOAD_SIZE && $urandom_range(3) != 0) begin
         t.va = $urandom_range(6 * 65536);
         t.vb = $urandom_range(6 * 65536);
         t.vc = $urandom_range(6 * 65536);
         t.vd = $urandom_range(65536);
      end
      return t;
   endfunction

   function automatic sdf_beat_type rand_query();
      return make_beat(REQ_QUERY, $urandom_range(7), $urandom_range(7),
                       rand_fixed(12), rand_fixed(12), rand_fixed(12), int'($urandom));
   endfunction

   // directed: every kind, zero and extreme quaternions, odd sizes, count edges
   task automatic test_directed();
      set_count(0);
      send_beat(make_beat(REQ_QUERY, 0, 0, 32'sh7fffffff, 32'sh80000000, 0, -1));
      for (int e = 0; e < MAX_PRIMITIVES; e++) begin
         send_beat(make_beat(REQ_LOAD_POSE, e, e % 5, e * 65536, -e * 32768, 65536, 0));
         send_beat(make_beat(REQ_LOAD_SIZE, e, 0, 2 * 65536, 65536, 3 * 65536, 16384));
      end
      send_beat(make_beat(REQ_LOAD_QUAT, 0, 0, 0, 0, 0, 0));
      send_beat(make_beat(REQ_LOAD_QUAT, 1, 0, 32'sh80000000, 32'sh7fffffff,
                          32'sh80000000, 32'sh7fffffff));
      send_beat(make_beat(REQ_LOAD_QUAT, 2, 0, 0, 0, 0, 1));
      send_beat(make_beat(REQ_LOAD_QUAT, 3, 0, 46341, 46341, 0, 0));
      // capsule with a negative half length
      send_beat(make_beat(REQ_LOAD_SIZE, 3, 0, -4 * 65536, 65536, 0, 0));
      for (int e = 4; e < MAX_PRIMITIVES; e++)
         send_beat(make_beat(REQ_LOAD_QUAT, e, 0, 65536, e * 9000, -e * 7000, 3000));
      set_count(15);
      send_beat(make_beat(REQ_QUERY, 0, 0, 0, 0, 0, 0));
      send_beat(make_beat(REQ_QUERY, 0, 0, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0));
      send_beat(make_beat(REQ_QUERY, 0, 0, 32'sh80000000, 32'sh80000000, 32'sh80000000, 0));
      set_count(8);
      send_beat(make_beat(REQ_QUERY, 0, 0, 65536, -65536, 32768, 0));
      // an unknown kind among the counted entries
      send_beat(make_beat(REQ_LOAD_POSE, 5, 7, 0, 0, 0, 0));
      send_beat(make_beat(REQ_QUERY, 0, 0, 65536, 65536, 65536, 0));
      set_count(5);
      send_beat(make_beat(REQ_QUERY, 0, 0, 65536, 65536, 65536, 0));
   endtask

   // random phases, each under its own count setting
   task automatic test_random(int phases, int beats_per_phase);
      int pick, n;
      for (int ph = 0; ph < phases; ph++) begin
         n = $urandom_range(9);
         if (n > 6) n = $urandom_range(15, 8);
         else if (n > 3) n = $urandom_range(3, 1);
         set_count(n);
         for (int i = 0; i < beats_per_phase; i++) begin
            pick = $urandom_range(99);
            if (pick < 60) send_beat(rand_query());
            else if (pick < 75) send_beat(rand_load(REQ_LOAD_POSE));
            else if (pick < 92) send_beat(rand_load(REQ_LOAD_SIZE));
            else send_beat(rand_load(REQ_LOAD_QUAT));
         end
      end
   endtask

   // hold the receiver off while queries keep coming, then pause the sender
   task automatic test_backpressure();
      set_count(2);
      rsp_hold_left = 600;
      for (int i = 0; i < 30; i++) send_beat(rand_query());
      req_bus.valid <= 1'b0;
      while (pending_dist.size() != 0) @(posedge clock);
      for (int i = 0; i < 10; i++) send_beat(rand_query());
   endtask

   // receiver ready, with stalls and an optional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (rsp_hold_left > 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_hold_left <= rsp_hold_left - 1;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // compare each response beat with the oldest expected one
   always @(posedge clock) begin
      sdf_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_dist.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected beat: distance %0d status %0d",
                        rsp_bus.distance, rsp_bus.status);
         end else begin
            want = pending_dist.pop_front();
            if (want.dvalue !== rsp_bus.distance || want.stat !== rsp_bus.status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected distance %0d status %0d, got %0d status %0d",
                           want.dvalue, want.stat, rsp_bus.distance, rsp_bus.status);
            end
         end
      end
   end

   // watchdog on cycles without any accepted beat
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("tb_analytic_sdf_union_unit: errors");
         $finish;
      end
   end

   initial begin
      reset         = 1'b1;
      csr_wr_en     = 1'b0;
      csr_wr_data   = '0;
      req_bus.valid = 1'b0;
      req_bus.req_type    = REQ_QUERY;
      req_bus.entry_index = '0;
      req_bus.shape_kind  = KIND_RBOX;
      req_bus.value_a = '0;
      req_bus.value_b = '0;
      req_bus.value_c = '0;
      req_bus.value_d = '0;
      mismatches    = 0;
      idle_cycles   = 0;
      rsp_hold_left = 0;
      active_count  = 0;
      send_gap_pct  = 11;
      rsp_stall_pct = 73;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random(4, 115);
      send_gap_pct  = 73;
      rsp_stall_pct = 11;
      test_random(4, 115);
      send_gap_pct  = 0;
      rsp_stall_pct = 0;
      test_random(4, 115);
      test_backpressure();
      drain_all();

      if (mismatches == 0 && pending_dist.size() == 0)
         $display("tb_analytic_sdf_union_unit: clean");
      else
         $display("tb_analytic_sdf_union_unit: errors");
      $finish;
   end

endmodule
